>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

>>> design/kmsr_pkg.sv
// ----------------------------------------------------------------------------
// kmsr_pkg
// Shared types and constants of the keyboard matrix scan responder
// ----------------------------------------------------------------------------
package kmsr_pkg;

  // action codes carried on in_tuser
  localparam logic [1:0] ACT_RISE = 2'd0;
  localparam logic [1:0] ACT_FALL = 2'd1;
  localparam logic [1:0] ACT_KEY  = 2'd2;

  localparam int KEY_FIELD_W = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // counter and led constants
  localparam logic [7:0] LO_NIB_CLEAR  = 8'hF0;
  localparam logic [7:0] HI_NIB_CLEAR  = 8'h0F;
  localparam logic [7:0] LED_CNT_MASK  = 8'h0E;
  localparam logic [7:0] LED_PREV_INIT = 8'h01;

  // input item, last field in the lowest bits
  typedef struct packed {
    logic                   key_pressed;
    logic [KEY_FIELD_W-1:0] key_index;
    logic                   led_line_low;
    logic                   scan_clock_high;
    logic                   reset_line_high_nibble;
    logic                   reset_line_low_nibble;
  } kmsr_in_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic       caps_lamp;
    logic       kana_hiragana_lamp;
    logic       kana_katakana_lamp;
    logic       led_changed;
    logic [7:0] led_byte;
    logic       key_sense;
  } kmsr_out_t;

  // key bitmap write request
  typedef struct packed {
    logic                   en;
    logic [KEY_FIELD_W-1:0] idx;
    logic                   val;
  } kmsr_key_wr_t;

endpackage

>>> design/kmsr_key_map.sv
// ----------------------------------------------------------------------------
// kmsr_key_map
// Key-pressed bitmap with one write port and one registered read port,
// cleared one key per cycle after reset
// ----------------------------------------------------------------------------
module kmsr_key_map
  import kmsr_pkg::*;
#(
  parameter int KEY_COUNT = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kmsr_key_wr_t           wr,
  input  logic                   rd_en,
  input  logic [KEY_FIELD_W-1:0] rd_idx,
  output logic                   rd_bit,
  output logic                   ready
);

  localparam int MAP_IDX_W = $clog2(KEY_COUNT);
  localparam logic [KEY_FIELD_W:0] KEY_LIMIT = (KEY_FIELD_W + 1)'(KEY_COUNT);
  localparam logic [MAP_IDX_W-1:0] LAST_IDX  = MAP_IDX_W'(KEY_COUNT - 1);

  logic                 key_mem [KEY_COUNT];
  logic                 clr_busy_r;
  logic [MAP_IDX_W-1:0] clr_idx_r;
  logic                 rd_bit_r;
  logic                 wr_in_range;
  logic                 rd_in_range;
  logic                 wr_hit;

  // keys beyond the map are ignored on write and read as released
  assign wr_in_range = ({1'b0, wr.idx} < KEY_LIMIT);
  assign rd_in_range = ({1'b0, rd_idx} < KEY_LIMIT);
  assign wr_hit      = wr.en && wr_in_range && (wr.idx == rd_idx);

  // clearing pass after reset, one key per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_busy_r <= (clr_idx_r != LAST_IDX);
      clr_idx_r  <= clr_idx_r + MAP_IDX_W'(1);
    end
  end

  // bitmap write port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      key_mem[clr_idx_r] <= 1'b0;
    end else if (wr.en && wr_in_range) begin
      key_mem[wr.idx[MAP_IDX_W-1:0]] <= wr.val;
    end
  end

  // registered read, a write to the same key in the same cycle wins
  always_ff @(posedge clk) begin
    if (rd_en) begin
      priority if (!rd_in_range) begin
        rd_bit_r <= 1'b0;
      end else if (wr_hit) begin
        rd_bit_r <= wr.val;
      end else begin
        rd_bit_r <= key_mem[rd_idx[MAP_IDX_W-1:0]];
      end
    end
  end

  assign rd_bit = rd_bit_r;
  assign ready  = !clr_busy_r;

endmodule

>>> design/keyboard_matrix_scan_responder.sv
// ----------------------------------------------------------------------------
// keyboard_matrix_scan_responder
// Key side of a host-scanned keyboard: scan counter, key sense and led latch
// ----------------------------------------------------------------------------
// A transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle unless the result channel stalls; the
// key bit for a rise is read from the key map as the transaction enters the
// input register. Reset (rst_n, synchronous, active low) clears the counter,
// sense and lamps, sets the previous led status to 1 and the invert mask to 0,
// then clears the key map one key per cycle with in_tready held low.
module keyboard_matrix_scan_responder
  import kmsr_pkg::*;
#(
  parameter int KEY_COUNT = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata: reset_line_low_nibble, reset_line_high_nibble, scan_clock_high,
  //        led_line_low, key_index[6:0], key_pressed, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: action[1:0]
  input  logic [1:0]             in_tuser,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: key_sense, led_byte[7:0], led_changed, kana_katakana_lamp,
  //        kana_hiragana_lamp, caps_lamp, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data
);

`include "assert_macros.svh"

  localparam int IN_ITEM_W  = $bits(kmsr_in_t);
  localparam int OUT_ITEM_W = $bits(kmsr_out_t);

  // handshake and stage control
  logic         out_free;
  logic         s1_adv;
  logic         s1_vld_r;
  logic [1:0]   s1_act_r;
  kmsr_in_t     s1_item_r;
  logic         out_vld_r;
  kmsr_out_t    out_item_r;
  kmsr_out_t    out_item_nxt;
  kmsr_in_t     in_item;
  logic         in_acc;
  logic         map_ready;

  // scan state
  logic [7:0]   led_inv_r;
  logic [7:0]   cnt_r,       cnt_nxt;
  logic [7:0]   led_cur_r,   led_cur_nxt;
  logic [7:0]   led_prev_r,  led_prev_nxt;
  logic         sense_r,     sense_nxt;
  logic [2:0]   lamps_r,     lamps_nxt;

  // datapath
  logic [7:0]   cnt_rise;
  logic [7:0]   cnt_base;
  logic [7:0]   cnt_pre;
  logic [7:0]   led_new;
  logic [2:0]   lamps_new;
  logic         changed;
  logic         rd_bit;
  kmsr_key_wr_t key_wr;

  // count after a rise, with the nibble clears applied
  function automatic logic [7:0] rise_count(input logic [7:0] cnt, input logic clr_lo,
                                            input logic clr_hi);
    logic [7:0] c;
    c = cnt + 8'd1;
    if (clr_lo) begin
      c = c & LO_NIB_CLEAR;
    end
    if (clr_hi) begin
      c = c & HI_NIB_CLEAR;
    end
    return c;
  endfunction

  assign in_item   = kmsr_in_t'(in_tdata[IN_ITEM_W-1:0]);
  assign out_free  = !out_vld_r || out_tready;
  assign s1_adv    = s1_vld_r && out_free;
  assign in_tready = map_ready && (!s1_vld_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r  <= in_tuser;
      s1_item_r <= in_item;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_inv_r <= '0;
    end else if (cfg_wr_en) begin
      led_inv_r <= cfg_wr_data;
    end
  end

  // count the incoming transaction sees, used to fetch its key bit early
  assign cnt_base = s1_adv ? cnt_nxt : cnt_r;
  assign cnt_pre  = rise_count(cnt_base, in_item.reset_line_low_nibble,
                               in_item.reset_line_high_nibble);

  // key bitmap
  kmsr_key_map #(
    .KEY_COUNT (KEY_COUNT)
  ) u_key_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (key_wr),
    .rd_en  (in_acc),
    .rd_idx (cnt_pre[7:1]),
    .rd_bit (rd_bit),
    .ready  (map_ready)
  );

  // counter step with nibble clears on a rise
  assign cnt_rise = rise_count(cnt_r, s1_item_r.reset_line_low_nibble,
                               s1_item_r.reset_line_high_nibble);

  // led status and lamp pattern latched on a fall
  assign led_new   = (cnt_r & LED_CNT_MASK) ^ led_inv_r;
  assign lamps_new = {led_new[3], ~led_new[2], ~led_new[1]};

  // next state per action
  always_comb begin
    cnt_nxt      = cnt_r;
    led_cur_nxt  = led_cur_r;
    led_prev_nxt = led_prev_r;
    sense_nxt    = sense_r;
    lamps_nxt    = lamps_r;
    changed      = 1'b0;
    key_wr       = '0;
    unique case (s1_act_r)
      ACT_RISE: begin
        cnt_nxt   = cnt_rise;
        sense_nxt = (!cnt_rise[0] && s1_item_r.scan_clock_high) ? rd_bit : 1'b0;
      end
      ACT_FALL: begin
        sense_nxt = 1'b0;
        if (s1_item_r.led_line_low) begin
          led_cur_nxt = led_new;
          if (led_new != led_prev_r) begin
            led_prev_nxt = led_new;
            lamps_nxt    = lamps_new;
            changed      = 1'b1;
          end
        end
      end
      ACT_KEY: begin
        key_wr.en  = s1_adv;
        key_wr.idx = s1_item_r.key_index;
        key_wr.val = s1_item_r.key_pressed;
      end
      default: begin
      end
    endcase
  end

  // state registers, updated as a transaction leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      led_cur_r  <= '0;
      led_prev_r <= LED_PREV_INIT;
      sense_r    <= 1'b0;
      lamps_r    <= '0;
    end else if (s1_adv) begin
      cnt_r      <= cnt_nxt;
      led_cur_r  <= led_cur_nxt;
      led_prev_r <= led_prev_nxt;
      sense_r    <= sense_nxt;
      lamps_r    <= lamps_nxt;
    end
  end

  // result assembly
  always_comb begin
    out_item_nxt.key_sense          = sense_nxt;
    out_item_nxt.led_byte           = led_cur_nxt;
    out_item_nxt.led_changed        = changed;
    out_item_nxt.kana_katakana_lamp = lamps_nxt[0];
    out_item_nxt.kana_hiragana_lamp = lamps_nxt[1];
    out_item_nxt.caps_lamp          = lamps_nxt[2];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_ITEM_W)'(0), out_item_r};

  // sense can only be set at an even count
  `ASSERT_NEVER(a_sense_even, sense_r && cnt_r[0], "key sense high at odd scan count")

  // a latching fall leaves current and previous led status equal
  `ASSERT_PROP(a_led_latch,
               s1_adv && (s1_act_r == ACT_FALL) && s1_item_r.led_line_low
               |=> led_cur_r == led_prev_r,
               "led status not latched on fall")

  // a fall always clears the sense level
  `ASSERT_PROP(a_fall_clear, s1_adv && (s1_act_r == ACT_FALL) |=> !sense_r,
               "sense not cleared on fall")

  // a reported change carries lamps that match the status
  `ASSERT_PROP(a_lamps_match,
               out_vld_r && out_item_r.led_changed
               |-> (out_item_r.caps_lamp == out_item_r.led_byte[3])
                   && (out_item_r.kana_hiragana_lamp != out_item_r.led_byte[2])
                   && (out_item_r.kana_katakana_lamp != out_item_r.led_byte[1]),
               "lamps disagree with led status")

endmodule

>>> tb/keyboard_matrix_scan_responder_tb.sv
// ----------------------------------------------------------------------------
// keyboard_matrix_scan_responder_tb
// Drives scan clock edges, key bitmap writes and unused actions into the
// responder under random stalls on both channels. A scoreboard class tracks
// the scan counter, key bitmap and led latch, and checks every result
// transaction field by field, in order.
// ----------------------------------------------------------------------------
module keyboard_matrix_scan_responder_tb;
  import kmsr_pkg::*;

  // the one action code the package leaves unnamed
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         KEY_COUNT  = 128;
  localparam int         OUT_W      = $bits(kmsr_out_t);
  localparam int         IN_W       = $bits(kmsr_in_t);

  // predicts the responder and holds the results still to come
  class scan_scoreboard;
    logic [7:0] invert_mask;
    logic [7:0] scan_count;
    logic [7:0] led_current;
    logic [7:0] led_previous;
    logic       sense_level;
    logic [2:0] lamp_levels;
    logic       key_map [KEY_COUNT];
    kmsr_out_t  expected_results [$];
    int         errors;

    function new();
      invert_mask  = '0;
      scan_count   = '0;
      led_current  = '0;
      led_previous = LED_PREV_INIT;
      sense_level  = 1'b0;
      lamp_levels  = '0;
      foreach (key_map[i]) key_map[i] = 1'b0;
      errors = 0;
    endfunction

    function void set_mask(logic [7:0] value);
      invert_mask = value;
    endfunction

    // one accepted input transaction updates the state and queues its result
    function void note_input(logic [1:0] action, logic [IN_TDATA_W-1:0] data);
      kmsr_in_t  item;
      kmsr_out_t res;
      logic      changed;
      item    = data[$bits(kmsr_in_t)-1:0];
      changed = 1'b0;
      case (action)
        ACT_RISE: begin
          scan_count = scan_count + 8'd1;
          if (item.reset_line_low_nibble) scan_count = scan_count & LO_NIB_CLEAR;
          if (item.reset_line_high_nibble) scan_count = scan_count & HI_NIB_CLEAR;
          if (!scan_count[0] && item.scan_clock_high && scan_count[7:1] < KEY_COUNT)
            sense_level = key_map[scan_count[7:1]];
          else
            sense_level = 1'b0;
        end
        ACT_FALL: begin
          sense_level = 1'b0;
          if (item.led_line_low) begin
            led_current = (scan_count & LED_CNT_MASK) ^ invert_mask;
            if (led_current != led_previous) begin
              lamp_levels[0] = !led_current[1];
              lamp_levels[1] = !led_current[2];
              lamp_levels[2] = led_current[3];
              led_previous   = led_current;
              changed        = 1'b1;
            end
          end
        end
        ACT_KEY: begin
          if (item.key_index < KEY_COUNT) key_map[item.key_index] = item.key_pressed;
        end
        default: begin
        end
      endcase
      res.key_sense          = sense_level;
      res.led_byte           = led_current;
      res.led_changed        = changed;
      res.kana_katakana_lamp = lamp_levels[0];
      res.kana_hiragana_lamp = lamp_levels[1];
      res.caps_lamp          = lamp_levels[2];
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    // one accepted result transaction against the oldest expectation
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      kmsr_out_t exp_r;
      kmsr_out_t act_r;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual %h", $time, data);
        return;
      end
      exp_r = expected_results.pop_front();
      act_r = data[OUT_W-1:0];
      compare_field("key_sense", 8'(exp_r.key_sense), 8'(act_r.key_sense));
      compare_field("led_byte", exp_r.led_byte, act_r.led_byte);
      compare_field("led_changed", 8'(exp_r.led_changed), 8'(act_r.led_changed));
      compare_field("kana_katakana_lamp", 8'(exp_r.kana_katakana_lamp),
                    8'(act_r.kana_katakana_lamp));
      compare_field("kana_hiragana_lamp", 8'(exp_r.kana_hiragana_lamp),
                    8'(act_r.kana_hiragana_lamp));
      compare_field("caps_lamp", 8'(exp_r.caps_lamp), 8'(act_r.caps_lamp));
      compare_field("zero fill", '0, 8'(data[OUT_TDATA_W-1:OUT_W]));
    endfunction
  endclass

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [1:0]             in_tuser    = ACT_RISE;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [7:0]             cfg_wr_data = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  scan_scoreboard sb = new();

  keyboard_matrix_scan_responder #(
    .KEY_COUNT (KEY_COUNT)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watch both channels
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  function automatic kmsr_in_t make_item(logic lo, logic hi, logic clk_hi, logic led_lo,
                                         logic [KEY_FIELD_W-1:0] idx, logic pressed);
    kmsr_in_t it;
    it.reset_line_low_nibble  = lo;
    it.reset_line_high_nibble = hi;
    it.scan_clock_high        = clk_hi;
    it.led_line_low           = led_lo;
    it.key_index              = idx;
    it.key_pressed            = pressed;
    return it;
  endfunction

  // present one transaction, with random sender gaps ahead of it
  task automatic send_item(input logic [1:0] action, input kmsr_in_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {{(IN_TDATA_W - $bits(kmsr_in_t)){1'b0}}, item};
    do @(posedge clk); while (!in_tready);
  endtask

  // mostly scan edges with rare counter resets, some key writes and noise
  task automatic send_random_item();
    logic [$bits(kmsr_in_t)-1:0] raw;
    kmsr_in_t                    it;
    logic [1:0]                  action;
    int                          pick;
    raw  = IN_W'($urandom);
    it   = raw;
    pick = $urandom_range(99);
    if (pick < 35) begin
      action = ACT_RISE;
      it.reset_line_low_nibble  = ($urandom_range(9) == 0);
      it.reset_line_high_nibble = ($urandom_range(9) == 0);
    end else if (pick < 70) begin
      action = ACT_FALL;
    end else if (pick < 95) begin
      action = ACT_KEY;
    end else begin
      action = ACT_UNUSED;
    end
    send_item(action, it);
  endtask

  // wait for the block to drain, then write the invert mask
  task automatic write_mask(input logic [7:0] value);
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_mask(value);
  endtask

  // run timeout
  initial begin
    #400000;
    $display("keyboard_matrix_scan_responder_tb: errors");
    $finish;
  end

  // stimulus
  initial begin
    kmsr_in_t it;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: key writes, resets, sense readback, led latch, unused action
    send_item(ACT_KEY,  make_item(1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b1));
    send_item(ACT_KEY,  make_item(1'b0, 1'b0, 1'b0, 1'b0, 7'd1,   1'b1));
    send_item(ACT_KEY,  make_item(1'b1, 1'b1, 1'b1, 1'b1, 7'd127, 1'b1));
    send_item(ACT_KEY,  make_item(1'b0, 1'b0, 1'b0, 1'b0, 7'd2,   1'b0));
    // both reset lines bring the count to zero
    send_item(ACT_RISE, make_item(1'b1, 1'b1, 1'b1, 1'b0, 7'd0,   1'b0));
    send_item(ACT_FALL, make_item(1'b0, 1'b0, 1'b0, 1'b1, 7'd0,   1'b0));
    // fall with unchanged led status
    send_item(ACT_FALL, make_item(1'b0, 1'b0, 1'b0, 1'b1, 7'd0,   1'b0));
    send_item(ACT_RISE, make_item(1'b0, 1'b0, 1'b1, 1'b0, 7'd0,   1'b0));
    send_item(ACT_RISE, make_item(1'b0, 1'b0, 1'b1, 1'b0, 7'd0,   1'b0));
    // fall with led line high only clears sense
    send_item(ACT_FALL, make_item(1'b0, 1'b0, 1'b1, 1'b0, 7'd127, 1'b1));
    send_item(ACT_RISE, make_item(1'b0, 1'b0, 1'b0, 1'b1, 7'd127, 1'b1));
    send_item(ACT_RISE, make_item(1'b0, 1'b0, 1'b1, 1'b0, 7'd0,   1'b0));
    send_item(ACT_FALL, make_item(1'b0, 1'b0, 1'b0, 1'b1, 7'd0,   1'b0));
    // unused action leaves everything alone
    send_item(ACT_UNUSED, make_item(1'b1, 1'b1, 1'b1, 1'b1, 7'd127, 1'b1));
    send_item(ACT_RISE, make_item(1'b1, 1'b0, 1'b1, 1'b0, 7'd0,   1'b0));
    send_item(ACT_RISE, make_item(1'b0, 1'b1, 1'b1, 1'b0, 7'd0,   1'b0));
    send_item(ACT_RISE, make_item(1'b0, 1'b0, 1'b1, 1'b1, 7'd64,  1'b1));
    send_item(ACT_FALL, make_item(1'b1, 1'b1, 1'b1, 1'b1, 7'd64,  1'b1));
    send_item(ACT_KEY,  make_item(1'b1, 1'b1, 1'b1, 1'b1, 7'd64,  1'b1));
    send_item(ACT_KEY,  make_item(1'b1, 1'b1, 1'b1, 1'b1, 7'd0,   1'b0));
    send_item(ACT_RISE, make_item(1'b0, 1'b0, 1'b1, 1'b0, 7'd0,   1'b0));

    // sender mostly busy, receiver mostly stalled, mask all ones
    tx_idle_pct = 16;
    rx_idle_pct = 81;
    write_mask(8'hFF);
    repeat (120) send_random_item();

    // the other way round, with a full counter sweep that wraps
    tx_idle_pct = 81;
    rx_idle_pct = 16;
    write_mask(8'($urandom));
    repeat (260) begin
      it = make_item(1'b0, 1'b0, 1'b1, 1'(($urandom)), 7'($urandom), 1'($urandom));
      send_item(ACT_RISE, it);
    end
    repeat (80) send_random_item();

    // no idling, mask back to zero, then low bit only
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_mask(8'h00);
    repeat (60) send_random_item();
    write_mask(8'h01);
    repeat (60) send_random_item();

    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("keyboard_matrix_scan_responder_tb: clean");
    else
      $display("keyboard_matrix_scan_responder_tb: errors");
    $finish;
  end

endmodule
